// ----- hdl/matrix3_inverse_defines.svh -----
// Assertion macros for the 3x3 matrix inverse block.
// Included by the modules that carry checks; needs clk and arst_n in scope.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, quiet while reset is asserted.
`define MI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("matrix3_inverse: check failed");
// Next-cycle implication, quiet while reset is asserted.
`define MI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("matrix3_inverse: check failed");
`else
`define MI_ASSERT_IMP(lbl, ante, cons)
`define MI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/matinv_pkg.sv -----
// Shared widths, types and constants for the 3x3 matrix inverse block.
// No dependencies.
`timescale 1ns / 1ps
package matinv_pkg;
	localparam int unsigned ENT_W      = 16;  // Q4.12 entry
	localparam int unsigned PROD_W     = 32;  // entry product
	localparam int unsigned COF_W      = 33;  // cofactor
	localparam int unsigned MAG_W      = 32;  // cofactor magnitude
	localparam int unsigned DET_W      = 49;  // determinant
	localparam int unsigned DEN_W      = 48;  // determinant magnitude
	localparam int unsigned RES_W      = 32;  // Q16.16 result
	localparam int unsigned QBITS      = 33;  // quotient bits resolved
	localparam int unsigned DIV_LAT    = QBITS + 3;
	localparam int unsigned IN_FRAC_DEF  = 12;
	localparam int unsigned OUT_FRAC_DEF = 16;
	localparam int unsigned DATA_IN_W  = 9 * ENT_W;
	localparam int unsigned DATA_OUT_W = ((9 * RES_W + DET_W + 7) / 8) * 8;

	typedef logic signed [ENT_W-1:0]  ent_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic signed [DET_W-1:0]  det_t;
	typedef logic signed [RES_W-1:0]  res_t;

	localparam res_t RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam res_t RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

	// cyclic successors of a row or column index
	localparam int unsigned NX1 [3] = '{1, 2, 0};
	localparam int unsigned NX2 [3] = '{2, 0, 1};

	typedef struct packed {
		logic en;   // pipeline advance
		logic vld;  // item entering
	} mi_ctl_t;
endpackage

// ----- hdl/matinv_cofactor.sv -----
// Input register, 2x2 minor products and cofactors (three stages).
// Depends on matinv_pkg.
`timescale 1ns / 1ps
module matinv_cofactor (
	input  logic             clk,
	input  logic             arst_n,
	input  matinv_pkg::mi_ctl_t ctl,
	input  matinv_pkg::ent_t a_in [3][3],
	output matinv_pkg::ent_t row0 [3],
	output matinv_pkg::cof_t cof [3][3],
	output logic             vld
);
	import matinv_pkg::*;

	ent_t  a_s1 [3][3];
	prod_t pa_s2 [3][3];
	prod_t pb_s2 [3][3];
	ent_t  row0_s2 [3];
	ent_t  row0_s3 [3];
	cof_t  cof_s3 [3][3];
	logic  vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			a_s1 <= a_in;
			for (int i = 0; i < 3; i++) begin
				row0_s2[i] <= a_s1[0][i];
				row0_s3[i] <= row0_s2[i];
				for (int j = 0; j < 3; j++) begin
					pa_s2[i][j] <= a_s1[NX1[i]][NX1[j]] * a_s1[NX2[i]][NX2[j]];
					pb_s2[i][j] <= a_s1[NX1[i]][NX2[j]] * a_s1[NX2[i]][NX1[j]];
					cof_s3[i][j] <= cof_t'(pa_s2[i][j]) - cof_t'(pb_s2[i][j]);
				end
			end
		end
	end

	assign row0 = row0_s3;
	assign cof  = cof_s3;
	assign vld  = vld_s3;
endmodule

// ----- hdl/matinv_det.sv -----
// Determinant by row-0 expansion: three products, then their sum.
// Depends on matinv_pkg.
`timescale 1ns / 1ps
module matinv_det (
	input  logic             clk,
	input  logic             arst_n,
	input  matinv_pkg::mi_ctl_t ctl,
	input  matinv_pkg::ent_t row0 [3],
	input  matinv_pkg::cof_t cof_in [3][3],
	output matinv_pkg::cof_t cof [3][3],
	output matinv_pkg::det_t det,
	output logic             vld
);
	import matinv_pkg::*;

	det_t pr_s4 [3];
	cof_t cof_s4 [3][3];
	cof_t cof_s5 [3][3];
	det_t det_s5;
	logic vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ctl.en) begin
			vld_s4 <= ctl.vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int j = 0; j < 3; j++) begin
				pr_s4[j] <= det_t'(row0[j]) * det_t'(cof_in[0][j]);
			end
			cof_s4 <= cof_in;
			cof_s5 <= cof_s4;
			det_s5 <= pr_s4[0] + pr_s4[1] + pr_s4[2];
		end
	end

	assign cof = cof_s5;
	assign det = det_s5;
	assign vld = vld_s5;
endmodule

// ----- hdl/matinv_div.sv -----
// Pipelined restoring divider: |num| * 2^SHIFT / |det|, one quotient bit
// per stage, rounded half away from zero and saturated. Depends on matinv_pkg.
`timescale 1ns / 1ps
module matinv_div #(
	parameter int unsigned SHIFT = matinv_pkg::IN_FRAC_DEF + matinv_pkg::OUT_FRAC_DEF
) (
	input  logic             clk,
	input  logic             en,
	input  matinv_pkg::cof_t num,
	input  matinv_pkg::det_t den,
	output matinv_pkg::res_t quo
);
	import matinv_pkg::*;

	localparam int unsigned CW = MAG_W + SHIFT + QBITS;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QBITS-1:0] lo;   // numerator bits still to bring down
		logic [QBITS-1:0] q;
		logic [DEN_W-1:0] md;
		logic             neg;
		logic             ovf;  // quotient beyond QBITS bits
	} dst_t;

	function automatic dst_t div_step(input dst_t s);
		logic [DEN_W:0] t;
		dst_t           r;
		t      = {s.rem, s.lo[QBITS-1]};
		r      = s;
		r.lo   = {s.lo[QBITS-2:0], 1'b0};
		if (t >= {1'b0, s.md}) begin
			r.rem = DEN_W'(t - {1'b0, s.md});
			r.q   = {s.q[QBITS-2:0], 1'b1};
		end else begin
			r.rem = t[DEN_W-1:0];
			r.q   = {s.q[QBITS-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [COF_W-1:0] nabs;
	logic [DET_W-1:0] dabs;
	logic [MAG_W-1:0] mn_s0;
	logic [DEN_W-1:0] md_s0;
	logic             neg_s0;
	logic [CW-1:0]    wide;
	dst_t             st_s [1:QBITS+1];
	logic [QBITS:0]   qr;
	logic             up;
	res_t             quo_s;

	assign nabs = num[COF_W-1] ? COF_W'(-num) : COF_W'(num);
	assign dabs = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
	assign wide = CW'(mn_s0) << SHIFT;

	// rounding on the final remainder
	assign up = {st_s[QBITS+1].rem, 1'b0} >= {1'b0, st_s[QBITS+1].md};
	assign qr = {1'b0, st_s[QBITS+1].q} + (QBITS+1)'(up);

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s0  <= nabs[MAG_W-1:0];
			md_s0  <= dabs[DEN_W-1:0];
			neg_s0 <= num[COF_W-1] ^ den[DET_W-1];

			st_s[1].rem <= DEN_W'(wide >> QBITS);
			st_s[1].lo  <= wide[QBITS-1:0];
			st_s[1].q   <= '0;
			st_s[1].md  <= md_s0;
			st_s[1].neg <= neg_s0;
			st_s[1].ovf <= (wide >> QBITS) >= CW'(md_s0);

			for (int k = 1; k <= QBITS; k++) begin
				st_s[k+1] <= div_step(st_s[k]);
			end

			if (st_s[QBITS+1].neg) begin
				if (st_s[QBITS+1].ovf || qr >= (QBITS+1)'(RES_MIN[RES_W-1:0]))
					quo_s <= RES_MIN;
				else
					quo_s <= res_t'(RES_W'(-qr));
			end else begin
				if (st_s[QBITS+1].ovf || qr > (QBITS+1)'(RES_MAX[RES_W-1:0]))
					quo_s <= RES_MAX;
				else
					quo_s <= res_t'(RES_W'(qr));
			end
		end
	end

	assign quo = quo_s;
endmodule

// ----- hdl/matrix3_inverse.sv -----
// Top level of the 3x3 matrix inverse: cofactor and determinant stages,
// nine dividers, side delay line and output skid. Depends on matinv_pkg,
// matinv_cofactor, matinv_det, matinv_div and matrix3_inverse_defines.svh.
//
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | tdata: a00 a01 a02 a10 a11 a12 a20 a21 a22 (16b each)
//  m_*     | out | tdata: b00..b22 (32b each), determinant (49b), pad
//          |     | tuser: singular
//
// One item per cycle sustained while the skid entry stays empty; 42 register
// stages lie between s_* and m_*: 5 cofactor/determinant stages, 36
// divider stages (magnitude, set-up, 33 quotient bits, round/saturate) and
// the output register.
// arst_n clears all valid bits; payload registers are not reset.
// A stall freezes the whole pipeline; the skid entry absorbs the item that
// lands while m_tready is low, and s_tready is the registered skid-empty flag.
`timescale 1ns / 1ps
`include "matrix3_inverse_defines.svh"
module matrix3_inverse #(
	parameter int unsigned IN_FRAC_BITS  = matinv_pkg::IN_FRAC_DEF,
	parameter int unsigned OUT_FRAC_BITS = matinv_pkg::OUT_FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [matinv_pkg::DATA_IN_W-1:0]   s_tdata,   // a00..a22
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [matinv_pkg::DATA_OUT_W-1:0]  m_tdata,   // b00..b22, determinant
	output logic                               m_tuser    // singular
);
	import matinv_pkg::*;

	localparam int unsigned PAD_W = DATA_OUT_W - 9 * RES_W - DET_W;

	typedef struct packed {
		logic           sing;
		det_t           det;
		res_t [8:0]     b;    // b[0] = b00 in the low bits
	} res_item_t;

	logic      en;
	mi_ctl_t   ctl;
	ent_t      a_in [3][3];
	ent_t      row0 [3];
	cof_t      cof3 [3][3];
	cof_t      cof5 [3][3];
	det_t      det5;
	logic      vld3, vld5;
	mi_ctl_t   ctl4;
	res_t [8:0] quo;

	// side delay line, matched to the divider latency
	logic      vld_d  [DIV_LAT];
	det_t      det_d  [DIV_LAT];
	logic      sing_d [DIV_LAT];

	logic      push;
	res_item_t push_item;
	res_item_t out_q, skid_q;
	logic      out_vld_q, skid_vld_q;

	// the whole pipeline moves while the skid entry is free
	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign ctl      = '{en: en, vld: s_tvalid};
	assign ctl4     = '{en: en, vld: vld3};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				a_in[r][c] = s_tdata[(r * 3 + c) * ENT_W +: ENT_W];
			end
		end
	end

	matinv_cofactor u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a_in   (a_in),
		.row0   (row0),
		.cof    (cof3),
		.vld    (vld3)
	);

	matinv_det u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl4),
		.row0   (row0),
		.cof_in (cof3),
		.cof    (cof5),
		.det    (det5),
		.vld    (vld5)
	);

	// inverse = adjugate / det, adjugate being the transposed cofactors
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			matinv_div #(
				.SHIFT (IN_FRAC_BITS + OUT_FRAC_BITS)
			) u_div (
				.clk (clk),
				.en  (en),
				.num (cof5[j][i]),
				.den (det5),
				.quo (quo[i * 3 + j])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) vld_d[k] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= vld5;
			for (int k = 1; k < DIV_LAT; k++) vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_d[0]  <= det5;
			sing_d[0] <= (det5 == '0);
			for (int k = 1; k < DIV_LAT; k++) begin
				det_d[k]  <= det_d[k-1];
				sing_d[k] <= sing_d[k-1];
			end
		end
	end

	// a singular matrix gives zeros throughout
	assign push           = en && vld_d[DIV_LAT-1];
	assign push_item.sing = sing_d[DIV_LAT-1];
	assign push_item.det  = det_d[DIV_LAT-1];
	assign push_item.b    = sing_d[DIV_LAT-1] ? '0 : quo;

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : push_item;
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q.det, out_q.b};
	assign m_tuser  = out_q.sing;

	`MI_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q)
	`MI_ASSERT_IMP(a_sing_zero_det, out_vld_q && out_q.sing, out_q.det == '0)
	`MI_ASSERT_IMP(a_skid_fill, $rose(skid_vld_q), $past(out_vld_q && !m_tready))
	`MI_ASSERT_NXT(a_skid_hold, skid_vld_q && !m_tready, skid_vld_q)
endmodule
